// ===== design/rcacc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the reprojection cost accumulator.
// No dependencies; every other design file except rcacc_checker uses this package.
package rcacc_pkg;

    localparam int WINDOW_LIMIT_DEFAULT = 64;
    localparam int CAM_W = 53;
    localparam int QUO_BITS = 22;
    localparam int RES_W = 21;
    localparam int SQ_W = 41;
    localparam int SUM_W = 57;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 54;

    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_X = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_INDEX = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 4'd7;

    typedef struct packed {
        logic [53:0] rot_row0;
        logic [53:0] rot_row1;
        logic [53:0] rot_row2;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic [5:0] window_index;
        logic [6:0] window_size;
    } cfg_t;

    typedef struct packed {
        logic qual;
        logic signed [CAM_W-1:0] cam_x;
        logic signed [CAM_W-1:0] cam_y;
        logic signed [CAM_W-1:0] cam_z;
        logic signed [RES_W-1:0] obs_x;
        logic signed [RES_W-1:0] obs_y;
        logic last;
    } entry_t;

endpackage

// ===== design/rcacc_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue that decouples the transform front from the division back.
// Depends on rcacc_pkg for the entry type.
module rcacc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rcacc_pkg::entry_t  din,
    output logic               full,
    input  logic               pop,
    output rcacc_pkg::entry_t  dout,
    output logic               empty
);
    rcacc_pkg::entry_t mem_reg [2];
    logic wr_ptr_reg;
    logic rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign dout = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== design/rcacc_front.sv =====
`timescale 1ns / 1ps
// Front: accepts points, checks qualification and forms camera coordinates.
// Depends on rcacc_pkg; feeds rcacc_queue.
module rcacc_front #(
    parameter int WINDOW_LIMIT = rcacc_pkg::WINDOW_LIMIT_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rcacc_pkg::cfg_t      cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_estimated_depth,
    input  logic [6:0]           s_observation_count,
    input  logic [5:0]           s_start_frame,
    input  logic [6:0]           s_end_frame,
    input  logic signed [31:0]   s_point_x,
    input  logic signed [31:0]   s_point_y,
    input  logic signed [31:0]   s_point_z,
    input  logic signed [20:0]   s_obs_x,
    input  logic signed [20:0]   s_obs_y,
    input  logic                 s_last_point,
    output logic                 q_push,
    output rcacc_pkg::entry_t    q_din,
    input  logic                 q_full
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;
    localparam int LIM_W = $clog2(WINDOW_LIMIT + 1) + 1;
    localparam int CMP_W = (LIM_W > 8) ? LIM_W : 8;

    logic [1:0] state_reg;
    logic [1:0] step_reg;
    logic qual_reg;
    logic last_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [20:0] ox_reg, oy_reg;
    logic signed [49:0] p0_reg, p1_reg, p2_reg;
    logic signed [rcacc_pkg::CAM_W-1:0] cx_reg, cy_reg, cz_reg;

    logic [CMP_W-1:0] wsize;
    logic qualify;
    logic [53:0] row;
    logic signed [31:0] tsel;
    logic signed [rcacc_pkg::CAM_W-1:0] row_sum;

    assign s_ready = (state_reg == F_IDLE);

    always_comb begin
        if ({{(CMP_W-7){1'b0}}, cfg.window_size} < CMP_W'(WINDOW_LIMIT)) begin
            wsize = {{(CMP_W-7){1'b0}}, cfg.window_size};
        end else begin
            wsize = CMP_W'(WINDOW_LIMIT);
        end
        qualify = (s_estimated_depth > 32'sd0) && (s_observation_count >= 7'd2)
            && (({{(CMP_W-6){1'b0}}, s_start_frame} + CMP_W'(1)) < wsize)
            && (s_start_frame <= cfg.window_index)
            && (s_end_frame >= {1'b0, cfg.window_index});
    end

    always_comb begin
        unique case (step_reg)
            2'd0: row = cfg.rot_row0;
            2'd1: row = cfg.rot_row1;
            default: row = cfg.rot_row2;
        endcase
        unique case (step_reg)
            2'd1: tsel = cfg.trans_x;
            2'd2: tsel = cfg.trans_y;
            default: tsel = cfg.trans_z;
        endcase
        row_sum = $signed({{3{p0_reg[49]}}, p0_reg}) + $signed({{3{p1_reg[49]}}, p1_reg})
            + $signed({{3{p2_reg[49]}}, p2_reg}) + $signed({{5{tsel[31]}}, tsel, 16'b0});
    end

    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign q_din = '{qual: qual_reg, cam_x: cx_reg, cam_y: cy_reg, cam_z: cz_reg,
                     obs_x: ox_reg, obs_y: oy_reg, last: last_reg};

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            px_reg <= s_point_x;
            py_reg <= s_point_y;
            pz_reg <= s_point_z;
            ox_reg <= s_obs_x;
            oy_reg <= s_obs_y;
            last_reg <= s_last_point;
            qual_reg <= qualify;
        end
        if (state_reg == F_MUL) begin
            p0_reg <= $signed(row[17:0]) * px_reg;
            p1_reg <= $signed(row[35:18]) * py_reg;
            p2_reg <= $signed(row[53:36]) * pz_reg;
            if (step_reg != 2'd0) begin
                cz_reg <= row_sum;
                cy_reg <= cz_reg;
                cx_reg <= cy_reg;
            end
        end
        if (!aresetn) begin
            state_reg <= F_IDLE;
            step_reg <= 2'd0;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        step_reg <= 2'd0;
                        state_reg <= qualify ? F_MUL : F_PUSH;
                    end
                end
                F_MUL: begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3) begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!q_full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule

// ===== design/rcacc_back.sv =====
`timescale 1ns / 1ps
// Back: divides by camera depth, forms saturated residuals and accumulates cost.
// Depends on rcacc_pkg; drains rcacc_queue and drives the result port.
module rcacc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    output logic                q_pop,
    input  rcacc_pkg::entry_t   q_dout,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_point_used,
    output logic signed [20:0]  m_residual_x,
    output logic signed [20:0]  m_residual_y,
    output logic                m_zero_depth_fault,
    output logic [15:0]         m_residual_total,
    output logic [55:0]         m_half_cost,
    output logic                m_last_result
);
    localparam int CW = rcacc_pkg::CAM_W;
    localparam int QB = rcacc_pkg::QUO_BITS;
    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_CHK = 3'd1;
    localparam logic [2:0] B_CLAMP = 3'd2;
    localparam logic [2:0] B_DIV = 3'd3;
    localparam logic [2:0] B_RES = 3'd4;
    localparam logic [2:0] B_SQ = 3'd5;
    localparam logic [2:0] B_OUT = 3'd6;

    logic [2:0] state_reg;
    logic [4:0] cnt_reg;
    rcacc_pkg::entry_t ent_reg;
    logic used_reg, fault_reg;
    logic negx_reg, negy_reg, clx_reg, cly_reg;
    logic [CW-1:0] ax_reg, ay_reg, b_reg;
    logic [CW:0] remx_reg, remy_reg;
    logic [QB-1:0] nx_reg, ny_reg, qx_reg, qy_reg;
    logic signed [20:0] rx_reg, ry_reg;
    logic [rcacc_pkg::SQ_W-1:0] sqx_reg, sqy_reg;
    logic [rcacc_pkg::SUM_W-1:0] sum_reg;
    logic [15:0] count_reg;

    logic [CW:0] remx2, remy2;
    logic signed [20:0] rx_next, ry_next;
    logic signed [41:0] sqx_full, sqy_full;
    logic [41:0] sq_add;
    logic [rcacc_pkg::SUM_W:0] sum_wide;
    logic [rcacc_pkg::SUM_W-1:0] sum_next;
    logic [15:0] count_next;
    logic out_free;

    function automatic logic signed [20:0] residual(logic neg, logic clamp,
                                                    logic [QB-1:0] q,
                                                    logic signed [20:0] obs);
        logic [22:0] mag;
        logic signed [24:0] sv;
        logic signed [24:0] d;
        mag = clamp ? 23'h400000 : {1'b0, q};
        sv = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        d = sv - $signed({{4{obs[20]}}, obs});
        if (d > 25'sd1048575) begin
            residual = 21'sh0FFFFF;
        end else if (d < -25'sd1048576) begin
            residual = 21'sh100000;
        end else begin
            residual = d[20:0];
        end
    endfunction

    assign q_pop = (state_reg == B_IDLE) && !q_empty;
    assign out_free = !m_valid || m_ready;

    always_comb begin
        remx2 = {remx_reg[CW-1:0], nx_reg[QB-1]};
        remy2 = {remy_reg[CW-1:0], ny_reg[QB-1]};
        rx_next = residual(negx_reg, clx_reg, qx_reg, ent_reg.obs_x);
        ry_next = residual(negy_reg, cly_reg, qy_reg, ent_reg.obs_y);
        sqx_full = rx_reg * rx_reg;
        sqy_full = ry_reg * ry_reg;
        sq_add = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        sum_wide = {1'b0, sum_reg} + {{(rcacc_pkg::SUM_W-41){1'b0}}, sq_add};
        sum_next = sum_reg;
        count_next = count_reg;
        if (used_reg) begin
            sum_next = sum_wide[rcacc_pkg::SUM_W] ? '1 : sum_wide[rcacc_pkg::SUM_W-1:0];
            count_next = (count_reg == 16'hFFFF) ? count_reg : count_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    ent_reg <= q_dout;
                end
            end
            B_CHK: begin
                rx_reg <= '0;
                ry_reg <= '0;
                used_reg <= ent_reg.qual && (ent_reg.cam_z != '0);
                fault_reg <= ent_reg.qual && (ent_reg.cam_z == '0);
                negx_reg <= ent_reg.cam_x[CW-1] ^ ent_reg.cam_z[CW-1];
                negy_reg <= ent_reg.cam_y[CW-1] ^ ent_reg.cam_z[CW-1];
                ax_reg <= ent_reg.cam_x[CW-1] ? CW'(-ent_reg.cam_x) : ent_reg.cam_x;
                ay_reg <= ent_reg.cam_y[CW-1] ? CW'(-ent_reg.cam_y) : ent_reg.cam_y;
                b_reg <= ent_reg.cam_z[CW-1] ? CW'(-ent_reg.cam_z) : ent_reg.cam_z;
            end
            B_CLAMP: begin
                clx_reg <= {6'b0, ax_reg} >= {b_reg, 6'b0};
                cly_reg <= {6'b0, ay_reg} >= {b_reg, 6'b0};
                remx_reg <= {7'b0, ax_reg[CW-1:6]};
                remy_reg <= {7'b0, ay_reg[CW-1:6]};
                nx_reg <= {ax_reg[5:0], 16'b0};
                ny_reg <= {ay_reg[5:0], 16'b0};
            end
            B_DIV: begin
                nx_reg <= {nx_reg[QB-2:0], 1'b0};
                ny_reg <= {ny_reg[QB-2:0], 1'b0};
                if (remx2 >= {1'b0, b_reg}) begin
                    remx_reg <= remx2 - {1'b0, b_reg};
                    qx_reg <= {qx_reg[QB-2:0], 1'b1};
                end else begin
                    remx_reg <= remx2;
                    qx_reg <= {qx_reg[QB-2:0], 1'b0};
                end
                if (remy2 >= {1'b0, b_reg}) begin
                    remy_reg <= remy2 - {1'b0, b_reg};
                    qy_reg <= {qy_reg[QB-2:0], 1'b1};
                end else begin
                    remy_reg <= remy2;
                    qy_reg <= {qy_reg[QB-2:0], 1'b0};
                end
            end
            B_RES: begin
                rx_reg <= rx_next;
                ry_reg <= ry_next;
            end
            B_SQ: begin
                sqx_reg <= sqx_full[rcacc_pkg::SQ_W-1:0];
                sqy_reg <= sqy_full[rcacc_pkg::SQ_W-1:0];
            end
            default: begin
            end
        endcase
        if (state_reg == B_OUT && out_free) begin
            m_point_used <= used_reg;
            m_residual_x <= rx_reg;
            m_residual_y <= ry_reg;
            m_zero_depth_fault <= fault_reg;
            m_residual_total <= count_next;
            m_half_cost <= sum_next[rcacc_pkg::SUM_W-1:1];
            m_last_result <= ent_reg.last;
        end
        if (!aresetn) begin
            state_reg <= B_IDLE;
            cnt_reg <= '0;
            m_valid <= 1'b0;
            sum_reg <= '0;
            count_reg <= '0;
        end else begin
            if (state_reg == B_OUT && out_free) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (!q_empty) begin
                        state_reg <= B_CHK;
                    end
                end
                B_CHK: begin
                    state_reg <= (ent_reg.qual && ent_reg.cam_z != '0) ? B_CLAMP : B_OUT;
                end
                B_CLAMP: begin
                    cnt_reg <= 5'(QB - 1);
                    state_reg <= B_DIV;
                end
                B_DIV: begin
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        state_reg <= B_RES;
                    end
                end
                B_RES: state_reg <= B_SQ;
                B_SQ: state_reg <= B_OUT;
                B_OUT: begin
                    if (out_free) begin
                        sum_reg <= ent_reg.last ? '0 : sum_next;
                        count_reg <= ent_reg.last ? '0 : count_next;
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule

// ===== design/reprojection_cost_accumulator_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Contents
// s_        in         s_valid / s_ready        one map point with its observation
// m_        out        m_valid / m_ready        residuals, fault flag, running totals
// cfg_      in         cfg_valid / cfg_ready    register index and write data
// A qualifying point goes from acceptance to result through the four-step transform in
// the front and the bit-serial divider in the back (22 quotient steps).
// A skipped point bypasses both; the back finishes one point before it takes the next.
// Reset is synchronous and active low; it restores the identity pose and clears totals.
// The queue lets the front take a new point while the back or the output stalls, until it fills.
// Depends on rcacc_pkg, rcacc_front, rcacc_queue and rcacc_back.
module reprojection_cost_accumulator_unit #(
    parameter int WINDOW_LIMIT = rcacc_pkg::WINDOW_LIMIT_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_index,
    input  logic [53:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_estimated_depth,
    input  logic [6:0]          s_observation_count,
    input  logic [5:0]          s_start_frame,
    input  logic [6:0]          s_end_frame,
    input  logic signed [31:0]  s_point_x,
    input  logic signed [31:0]  s_point_y,
    input  logic signed [31:0]  s_point_z,
    input  logic signed [20:0]  s_obs_x,
    input  logic signed [20:0]  s_obs_y,
    input  logic                s_last_point,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_point_used,
    output logic signed [20:0]  m_residual_x,
    output logic signed [20:0]  m_residual_y,
    output logic                m_zero_depth_fault,
    output logic [15:0]         m_residual_total,
    output logic [55:0]         m_half_cost,
    output logic                m_last_result
);
    rcacc_pkg::cfg_t cfg_reg;
    rcacc_pkg::entry_t q_din, q_dout;
    logic q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rot_row0 <= 54'd65536;
            cfg_reg.rot_row1 <= 54'd65536 << 18;
            cfg_reg.rot_row2 <= 54'd65536 << 36;
            cfg_reg.trans_x <= '0;
            cfg_reg.trans_y <= '0;
            cfg_reg.trans_z <= '0;
            cfg_reg.window_index <= '0;
            cfg_reg.window_size <= 7'd10;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rcacc_pkg::REG_ROT_ROW0: cfg_reg.rot_row0 <= cfg_data;
                rcacc_pkg::REG_ROT_ROW1: cfg_reg.rot_row1 <= cfg_data;
                rcacc_pkg::REG_ROT_ROW2: cfg_reg.rot_row2 <= cfg_data;
                rcacc_pkg::REG_TRANS_X: cfg_reg.trans_x <= cfg_data[31:0];
                rcacc_pkg::REG_TRANS_Y: cfg_reg.trans_y <= cfg_data[31:0];
                rcacc_pkg::REG_TRANS_Z: cfg_reg.trans_z <= cfg_data[31:0];
                rcacc_pkg::REG_WINDOW_INDEX: cfg_reg.window_index <= cfg_data[5:0];
                rcacc_pkg::REG_WINDOW_SIZE: cfg_reg.window_size <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    rcacc_front #(.WINDOW_LIMIT(WINDOW_LIMIT)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_estimated_depth(s_estimated_depth), .s_observation_count(s_observation_count),
        .s_start_frame(s_start_frame), .s_end_frame(s_end_frame),
        .s_point_x(s_point_x), .s_point_y(s_point_y), .s_point_z(s_point_z),
        .s_obs_x(s_obs_x), .s_obs_y(s_obs_y), .s_last_point(s_last_point),
        .q_push(q_push), .q_din(q_din), .q_full(q_full)
    );

    rcacc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .din(q_din), .full(q_full),
        .pop(q_pop), .dout(q_dout), .empty(q_empty)
    );

    rcacc_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_empty(q_empty), .q_pop(q_pop), .q_dout(q_dout),
        .m_valid(m_valid), .m_ready(m_ready), .m_point_used(m_point_used),
        .m_residual_x(m_residual_x), .m_residual_y(m_residual_y),
        .m_zero_depth_fault(m_zero_depth_fault), .m_residual_total(m_residual_total),
        .m_half_cost(m_half_cost), .m_last_result(m_last_result)
    );
endmodule

// ===== design/rcacc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the reprojection cost accumulator.
// Bound to reprojection_cost_accumulator_unit; no other dependencies.
module rcacc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_valid,
    input logic         m_ready,
    input logic         m_point_used,
    input logic [20:0]  m_residual_x,
    input logic [20:0]  m_residual_y,
    input logic         m_zero_depth_fault,
    input logic [15:0]  m_residual_total
);
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_residual_total) && $stable(m_residual_x))
        else $error("Stalled result transaction changed.");

    a_used_not_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_point_used && m_zero_depth_fault))
        else $error("Point reported both used and faulted.");

    a_skip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_point_used |-> m_residual_x == 21'd0 && m_residual_y == 21'd0)
        else $error("Skipped point carries a nonzero residual.");

    a_used_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_point_used |-> m_residual_total != 16'd0)
        else $error("Used point left the residual count at zero.");
endmodule

bind reprojection_cost_accumulator_unit rcacc_checker u_rcacc_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_point_used(m_point_used), .m_residual_x(m_residual_x),
    .m_residual_y(m_residual_y), .m_zero_depth_fault(m_zero_depth_fault),
    .m_residual_total(m_residual_total)
);
